>>> hdl/qm3_pkg.sv
package qm3_pkg;

    // Field widths and fixed-point formats
    localparam int COORD_WIDTH = 24;
    localparam int COEFF_WIDTH = 16;
    localparam int COORD_FRAC  = 16;
    localparam int COEFF_FRAC  = 13;

    // Polynomial shape: ten terms for each of three axes
    localparam int TERMS    = 10;
    localparam int AXES     = 3;
    localparam int NUM_REGS = 8;

    // Configuration port
    localparam int REG_W      = 64;
    localparam int LAST_REG_W = 32;
    localparam int CFG_IDX_W  = 4;

    // Stream data widths, padded to whole bytes
    localparam int PAYLOAD_W = AXES * COORD_WIDTH;
    localparam int TDATA_W   = ((PAYLOAD_W + 7) / 8) * 8;

    // Datapath widths
    localparam int PROD_W = 2 * COORD_WIDTH;
    localparam int TERM_W = COEFF_WIDTH + PROD_W;
    localparam int ACC_W  = TERM_W + 4;
    localparam int RND_SH = COORD_FRAC + COEFF_FRAC;
    localparam int RES_W  = ACC_W - RND_SH;

    typedef logic [TERMS-1:0][COEFF_WIDTH-1:0] axis_coef_t;

    // Input point and its pairwise products after the first stage
    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
        logic signed [PROD_W-1:0]      xx;
        logic signed [PROD_W-1:0]      yy;
        logic signed [PROD_W-1:0]      zz;
        logic signed [PROD_W-1:0]      xy;
        logic signed [PROD_W-1:0]      xz;
        logic signed [PROD_W-1:0]      yz;
    } point_t;

    // Per-stage load strobes of the pipeline
    typedef struct packed {
        logic load1;
        logic load2;
        logic load3;
        logic load4;
    } adv_t;

endpackage

>>> hdl/qm3_coef_regs.sv
module qm3_coef_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [qm3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qm3_pkg::REG_W-1:0]      cfg_data,
    output qm3_pkg::axis_coef_t            coef [qm3_pkg::AXES]
);

    localparam int SLOTS     = 4;
    localparam int REG_IDX_W = $clog2(qm3_pkg::NUM_REGS);

    logic [qm3_pkg::REG_W-1:0] pack_reg [qm3_pkg::NUM_REGS];
    logic [qm3_pkg::REG_W-1:0] wr_data;
    logic                      wr_en;

    // Pick one slot of a register; bits past the top read as zero
    function automatic logic [qm3_pkg::COEFF_WIDTH-1:0] coef_slot(
        input logic [qm3_pkg::REG_W-1:0] r,
        input int                        slot
    );
        logic [qm3_pkg::REG_W-1:0] s;
        s = r >> (slot * qm3_pkg::COEFF_WIDTH);
        return s[qm3_pkg::COEFF_WIDTH-1:0];
    endfunction

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid &&
                       (cfg_index < qm3_pkg::CFG_IDX_W'(qm3_pkg::NUM_REGS));

    // Mask the last, narrower register
    always_comb begin
        wr_data = cfg_data;
        if (cfg_index == qm3_pkg::CFG_IDX_W'(qm3_pkg::NUM_REGS - 1)) begin
            wr_data = {{(qm3_pkg::REG_W - qm3_pkg::LAST_REG_W){1'b0}},
                       cfg_data[qm3_pkg::LAST_REG_W-1:0]};
        end
    end

    // Store register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < qm3_pkg::NUM_REGS; i++) begin
                pack_reg[i] <= '0;
            end
        end else if (wr_en) begin
            pack_reg[cfg_index[REG_IDX_W-1:0]] <= wr_data;
        end
    end

    // Unpack coefficient g from register g/4, slot g%4
    for (genvar g = 0; g < qm3_pkg::AXES * qm3_pkg::TERMS; g++) begin : g_coef
        assign coef[g / qm3_pkg::TERMS][g % qm3_pkg::TERMS] =
            coef_slot(pack_reg[g / SLOTS], g % SLOTS);
    end

endmodule

>>> hdl/qm3_prod.sv
module qm3_prod (
    input  logic                                 aclk,
    input  qm3_pkg::adv_t                        adv,
    input  logic signed [qm3_pkg::COORD_WIDTH-1:0] in_x,
    input  logic signed [qm3_pkg::COORD_WIDTH-1:0] in_y,
    input  logic signed [qm3_pkg::COORD_WIDTH-1:0] in_z,
    output qm3_pkg::point_t                      point
);

    qm3_pkg::point_t point_reg;
    qm3_pkg::point_t point_next;

    // Form squares and cross products of the incoming point
    always_comb begin
        point_next.x  = in_x;
        point_next.y  = in_y;
        point_next.z  = in_z;
        point_next.xx = qm3_pkg::PROD_W'(in_x) * qm3_pkg::PROD_W'(in_x);
        point_next.yy = qm3_pkg::PROD_W'(in_y) * qm3_pkg::PROD_W'(in_y);
        point_next.zz = qm3_pkg::PROD_W'(in_z) * qm3_pkg::PROD_W'(in_z);
        point_next.xy = qm3_pkg::PROD_W'(in_x) * qm3_pkg::PROD_W'(in_y);
        point_next.xz = qm3_pkg::PROD_W'(in_x) * qm3_pkg::PROD_W'(in_z);
        point_next.yz = qm3_pkg::PROD_W'(in_y) * qm3_pkg::PROD_W'(in_z);
    end

    always_ff @(posedge aclk) begin
        if (adv.load1) begin
            point_reg <= point_next;
        end
    end

    assign point = point_reg;

endmodule

>>> hdl/qm3_axis.sv
module qm3_axis (
    input  logic                                   aclk,
    input  qm3_pkg::adv_t                          adv,
    input  qm3_pkg::axis_coef_t                    coef,
    input  qm3_pkg::point_t                        point,
    output logic signed [qm3_pkg::COORD_WIDTH-1:0] coord,
    output logic                                   ovf
);

    localparam int TW = qm3_pkg::TERM_W;
    localparam int AW = qm3_pkg::ACC_W;
    localparam int CW = qm3_pkg::COORD_WIDTH;
    localparam int RW = qm3_pkg::RES_W;

    localparam logic signed [AW-1:0] HALF = AW'(1) <<< (qm3_pkg::RND_SH - 1);
    localparam logic [CW-1:0] MAX_VAL = {1'b0, {(CW - 1){1'b1}}};
    localparam logic [CW-1:0] MIN_VAL = {1'b1, {(CW - 1){1'b0}}};

    logic signed [TW-1:0] term_next [qm3_pkg::TERMS];
    logic signed [TW-1:0] term_reg  [qm3_pkg::TERMS];
    logic signed [TW-1:0] c         [qm3_pkg::TERMS];
    logic signed [AW-1:0] sum_a_next, sum_b_next;
    logic signed [AW-1:0] sum_a_reg, sum_b_reg;
    logic signed [AW-1:0] total;
    logic signed [RW-1:0] rounded;
    logic [RW-CW:0]       upper;
    logic                 ovf_next, ovf_reg;
    logic [CW-1:0]        coord_next, coord_reg;

    // Sign-extend the coefficients
    always_comb begin
        for (int k = 0; k < qm3_pkg::TERMS; k++) begin
            c[k] = TW'($signed(coef[k]));
        end
    end

    // Stage 2: scale each term by its coefficient
    always_comb begin
        term_next[0] = c[0] <<< (2 * qm3_pkg::COORD_FRAC);
        term_next[1] = (c[1] * TW'(point.x)) <<< qm3_pkg::COORD_FRAC;
        term_next[2] = (c[2] * TW'(point.y)) <<< qm3_pkg::COORD_FRAC;
        term_next[3] = (c[3] * TW'(point.z)) <<< qm3_pkg::COORD_FRAC;
        term_next[4] = c[4] * TW'(point.xx);
        term_next[5] = c[5] * TW'(point.yy);
        term_next[6] = c[6] * TW'(point.zz);
        term_next[7] = c[7] * TW'(point.xy);
        term_next[8] = c[8] * TW'(point.xz);
        term_next[9] = c[9] * TW'(point.yz);
    end

    always_ff @(posedge aclk) begin
        if (adv.load2) begin
            for (int k = 0; k < qm3_pkg::TERMS; k++) begin
                term_reg[k] <= term_next[k];
            end
        end
    end

    // Stage 3: two partial sums, rounding half folded into the first
    assign sum_a_next = AW'(term_reg[0]) + AW'(term_reg[1]) + AW'(term_reg[2])
                      + AW'(term_reg[3]) + AW'(term_reg[4]) + HALF;
    assign sum_b_next = AW'(term_reg[5]) + AW'(term_reg[6]) + AW'(term_reg[7])
                      + AW'(term_reg[8]) + AW'(term_reg[9]);

    always_ff @(posedge aclk) begin
        if (adv.load3) begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
    end

    // Stage 4: final add, drop fraction bits, saturate
    always_comb begin
        total   = sum_a_reg + sum_b_reg;
        rounded = RW'(total >>> qm3_pkg::RND_SH);
        upper   = rounded[RW-1:CW-1];
        ovf_next = !((&upper) || !(|upper));
        if (ovf_next) begin
            coord_next = rounded[RW-1] ? MIN_VAL : MAX_VAL;
        end else begin
            coord_next = rounded[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv.load4) begin
            coord_reg <= coord_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign coord = $signed(coord_reg);
    assign ovf   = ovf_reg;

endmodule

>>> hdl/quadratic_3d_map_step_core.sv
// Pipeline: an accepted point passes through the product, coefficient, partial-sum
// and round/saturate stages in order before its result shows on m_tvalid.
// Throughput: one point per cycle; each stage holds only while the next is full.
// Reset: aresetn is synchronous and active low; it empties the pipeline and
// clears all coefficient registers to zero.
module quadratic_3d_map_step_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [qm3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qm3_pkg::REG_W-1:0]      cfg_data,
    // Input points
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [qm3_pkg::TDATA_W-1:0]    s_tdata,  // in_x, in_y, in_z
    // Result points
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [qm3_pkg::TDATA_W-1:0]    m_tdata,  // out_x, out_y, out_z
    output logic [0:0]                     m_tuser   // overflow
);

    localparam int CW     = qm3_pkg::COORD_WIDTH;
    localparam int STAGES = 4;

    qm3_pkg::axis_coef_t coef [qm3_pkg::AXES];
    qm3_pkg::point_t     point;
    qm3_pkg::adv_t       adv;

    logic [STAGES-1:0] valid_reg, valid_next, rdy;
    logic signed [CW-1:0] coord [qm3_pkg::AXES];
    logic [qm3_pkg::AXES-1:0] ovf;

    // Ready chain: a stage loads when empty or when its content moves on
    always_comb begin
        rdy[STAGES-1] = !valid_reg[STAGES-1] || m_tready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
        valid_next[0] = rdy[0] ? s_tvalid : valid_reg[0];
        for (int i = 1; i < STAGES; i++) begin
            valid_next[i] = rdy[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    assign adv.load1 = rdy[0];
    assign adv.load2 = rdy[1];
    assign adv.load3 = rdy[2];
    assign adv.load4 = rdy[3];

    assign s_tready = rdy[0];
    assign m_tvalid = valid_reg[STAGES-1];

    qm3_coef_regs u_coef_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    qm3_prod u_prod (
        .aclk  (aclk),
        .adv   (adv),
        .in_x  ($signed(s_tdata[CW-1:0])),
        .in_y  ($signed(s_tdata[2*CW-1:CW])),
        .in_z  ($signed(s_tdata[3*CW-1:2*CW])),
        .point (point)
    );

    for (genvar a = 0; a < qm3_pkg::AXES; a++) begin : g_axis
        qm3_axis u_axis (
            .aclk  (aclk),
            .adv   (adv),
            .coef  (coef[a]),
            .point (point),
            .coord (coord[a]),
            .ovf   (ovf[a])
        );
    end

    // Pack results, pad with zeros to whole bytes
    assign m_tdata = qm3_pkg::TDATA_W'({coord[2], coord[1], coord[0]});
    assign m_tuser = |ovf;

endmodule
